// ===== design/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg: shared definitions for the keyed value table
// Operation and status codes, port widths, default sizes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

	localparam int FUNC_W   = 3;
	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 3;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_KEY_BITS    = 32;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FN_LOOKUP   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SET      = 3'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_ALLOC    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_LOOK_SET = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_SET   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_KEY_ZERO  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

	// How the datapath forms the result when an operation finishes.
	localparam logic [1:0] FIN_DIRECT = 2'd0;
	localparam logic [1:0] FIN_HIT    = 2'd1;
	localparam logic [1:0] FIN_MISS   = 2'd2;

	typedef struct packed {
		logic       load;
		logic       scan_start;
		logic       scan_run;
		logic       clr_run;
		logic       grab_hit;
		logic       read_hit;
		logic       finish;
		logic [1:0] fin_mode;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              key_zero;
		logic              full;
		logic              key_match;
		logic              rd_pend;
		logic              scan_end;
	} stat_t;

endpackage

`default_nettype wire

// ===== design/keyed_value_table.sv =====
// ----------------------------------------------------------------------------
// keyed_value_table: associative key to value table
// Top level joining the operation sequencer and the storage datapath.
// ----------------------------------------------------------------------------
// Usage:
// An input word (func, key, value) is taken on in_valid && in_ready; a result
// word (value_out, new_key, status) is offered on out_valid until out_ready.
// Every input word gives exactly one result word, in order.
// Lookup, set and lookup-or-set search the valid entries in order, one entry
// per cycle through the key memory read port, then read back the hit entry's
// value and set flag. A miss scans all count entries, where count is the
// number of entries written so far (at most TABLE_DEPTH). Clear walks the set
// flags of those entries one entry per cycle. Allocate, zero keys and unknown
// codes skip the scan and give their result straight from dispatch.
// One word is worked on at a time; in_ready is high only when the sequencer
// is idle, so the next word can be taken in the cycle after a result is written.
// A finished result sits in the output registers, so the next word can be
// accepted while it waits; if the receiver stalls, the next result holds in
// the sequencer until the output registers are free. Reset empties the table
// and sets the allocation key to all ones; only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_value_table #(
	parameter int TABLE_DEPTH = kvt_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = kvt_pkg::DEF_KEY_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [kvt_pkg::FUNC_W-1:0]   func,
	input  wire logic [kvt_pkg::KEY_W-1:0]    key,
	input  wire logic [kvt_pkg::VALUE_W-1:0]  value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [kvt_pkg::VALUE_W-1:0]       value_out,
	output logic [kvt_pkg::KEY_W-1:0]         new_key,
	output logic [kvt_pkg::STATUS_W-1:0]      status
);

	// Commands flow from the sequencer into the datapath; status flows back.
	kvt_pkg::cmd_t  cmd;
	kvt_pkg::stat_t stat;

	kvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// The datapath keeps keys at KEY_BITS; the input key is truncated or
	// zero-extended to that width when loaded.
	kvt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.func      (func),
		.key       (key),
		.value     (value),
		.value_out (value_out),
		.new_key   (new_key),
		.status    (status)
	);

endmodule

`default_nettype wire

// ===== design/kvt_datapath.sv =====
// ----------------------------------------------------------------------------
// kvt_datapath: storage, scan pipeline and result formation
// Holds the key, value and set-flag memories, the operand registers, the
// entry count, the allocation key and the output word registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_datapath #(
	parameter int TABLE_DEPTH = kvt_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = kvt_pkg::DEF_KEY_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire kvt_pkg::cmd_t               cmd,
	output kvt_pkg::stat_t                   stat,
	input  wire logic [kvt_pkg::FUNC_W-1:0]  func,
	input  wire logic [kvt_pkg::KEY_W-1:0]   key,
	input  wire logic [kvt_pkg::VALUE_W-1:0] value,
	output logic [kvt_pkg::VALUE_W-1:0]      value_out,
	output logic [kvt_pkg::KEY_W-1:0]        new_key,
	output logic [kvt_pkg::STATUS_W-1:0]     status
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [KEY_BITS-1:0]         key_mem [TABLE_DEPTH];
	logic [kvt_pkg::VALUE_W-1:0] val_mem [TABLE_DEPTH];
	logic                        set_mem [TABLE_DEPTH];

	logic [kvt_pkg::FUNC_W-1:0]  func_q;
	logic [KEY_BITS-1:0]         key_q;
	logic [kvt_pkg::VALUE_W-1:0] value_q;
	logic [CW-1:0]               count_q;
	logic [KEY_BITS-1:0]         nfk_q;
	logic [CW-1:0]               scan_addr_q;
	logic [AW-1:0]               hit_idx_q;

	logic                        rd_pend_s1;
	logic [AW-1:0]               rd_idx_s1;
	logic [KEY_BITS-1:0]         key_rd_s1;
	logic [kvt_pkg::VALUE_W-1:0] val_rd_s1;
	logic                        set_rd_s1;

	logic                        full;
	logic                        scan_end;
	logic                        scan_rd;
	logic                        clr_wr;

	// Result and write requests formed at finish.
	logic [kvt_pkg::VALUE_W-1:0]  res_vo;
	logic [kvt_pkg::KEY_W-1:0]    res_nk;
	logic [kvt_pkg::STATUS_W-1:0] res_st;
	logic                         app;
	logic                         upd;
	logic                         alloc_take;
	logic [KEY_BITS-1:0]          app_key;
	logic [kvt_pkg::VALUE_W-1:0]  app_val;
	logic                         app_set;

	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign scan_end = (scan_addr_q >= count_q);
	assign scan_rd  = cmd.scan_run && !scan_end;
	assign clr_wr   = cmd.clr_run && !scan_end;

	assign stat.func      = func_q;
	assign stat.key_zero  = (key_q == '0);
	assign stat.full      = full;
	assign stat.key_match = rd_pend_s1 && (key_rd_s1 == key_q);
	assign stat.rd_pend   = rd_pend_s1;
	assign stat.scan_end  = scan_end;

	always_comb begin
		res_vo     = '0;
		res_nk     = '0;
		res_st     = kvt_pkg::ST_OK;
		app        = 1'b0;
		upd        = 1'b0;
		alloc_take = 1'b0;
		app_key    = key_q;
		app_val    = value_q;
		app_set    = 1'b1;
		case (cmd.fin_mode)
			kvt_pkg::FIN_DIRECT: begin
				case (func_q)
					kvt_pkg::FN_LOOKUP, kvt_pkg::FN_SET: begin
						res_st = kvt_pkg::ST_KEY_ZERO;
					end
					kvt_pkg::FN_LOOK_SET: begin
						res_vo = value_q;
						res_st = kvt_pkg::ST_KEY_ZERO;
					end
					kvt_pkg::FN_ALLOC: begin
						if (full) begin
							res_st = kvt_pkg::ST_FULL;
						end else begin
							app        = 1'b1;
							alloc_take = 1'b1;
							app_key    = nfk_q;
							app_val    = '0;
							app_set    = 1'b0;
							res_nk     = kvt_pkg::KEY_W'(nfk_q);
						end
					end
					default: begin
					end
				endcase
			end
			kvt_pkg::FIN_HIT: begin
				case (func_q)
					kvt_pkg::FN_LOOKUP: begin
						if (set_rd_s1) begin
							res_vo = val_rd_s1;
						end else begin
							res_st = kvt_pkg::ST_NOT_SET;
						end
					end
					kvt_pkg::FN_SET: begin
						upd = 1'b1;
					end
					kvt_pkg::FN_LOOK_SET: begin
						if (set_rd_s1) begin
							res_vo = val_rd_s1;
						end else begin
							upd    = 1'b1;
							res_vo = value_q;
						end
					end
					default: begin
					end
				endcase
			end
			kvt_pkg::FIN_MISS: begin
				case (func_q)
					kvt_pkg::FN_LOOKUP: begin
						res_st = kvt_pkg::ST_ABSENT;
					end
					kvt_pkg::FN_SET, kvt_pkg::FN_LOOK_SET: begin
						if (func_q == kvt_pkg::FN_LOOK_SET) begin
							res_vo = value_q;
						end
						// The top key bit set means the key lies at or above half range.
						if (key_q[KEY_BITS-1]) begin
							res_st = kvt_pkg::ST_TOO_LARGE;
						end else if (full) begin
							res_st = kvt_pkg::ST_FULL;
						end else begin
							app = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			nfk_q       <= '1;
			scan_addr_q <= '0;
			rd_pend_s1  <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_addr_q <= '0;
				rd_pend_s1  <= 1'b0;
			end else if (cmd.scan_run) begin
				rd_pend_s1 <= scan_rd;
				if (scan_rd) begin
					scan_addr_q <= scan_addr_q + 1'b1;
				end
			end else if (clr_wr) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (cmd.finish && app) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.finish && alloc_take) begin
				nfk_q <= nfk_q - 1'b1;
			end
		end
	end

	// Operands, scan pipeline and output words.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			key_q   <= KEY_BITS'(key);
			value_q <= value;
		end
		if (scan_rd) begin
			rd_idx_s1 <= scan_addr_q[AW-1:0];
		end
		if (cmd.grab_hit) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (cmd.finish) begin
			value_out <= res_vo;
			new_key   <= res_nk;
			status    <= res_st;
		end
	end

	// Key memory: one read port for the scan, one write port for appends.
	always_ff @(posedge clk) begin
		if (scan_rd) begin
			key_rd_s1 <= key_mem[scan_addr_q[AW-1:0]];
		end
		if (cmd.finish && app) begin
			key_mem[count_q[AW-1:0]] <= app_key;
		end
	end

	// Value memory.
	always_ff @(posedge clk) begin
		if (cmd.read_hit) begin
			val_rd_s1 <= val_mem[hit_idx_q];
		end
		if (cmd.finish && app) begin
			val_mem[count_q[AW-1:0]] <= app_val;
		end else if (cmd.finish && upd) begin
			val_mem[hit_idx_q] <= value_q;
		end
	end

	// Set-flag memory; the clear sweep shares its write port.
	always_ff @(posedge clk) begin
		if (cmd.read_hit) begin
			set_rd_s1 <= set_mem[hit_idx_q];
		end
		if (clr_wr) begin
			set_mem[scan_addr_q[AW-1:0]] <= 1'b0;
		end else if (cmd.finish && app) begin
			set_mem[count_q[AW-1:0]] <= app_set;
		end else if (cmd.finish && upd) begin
			set_mem[hit_idx_q] <= 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("entry count decreased");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && cmd.fin_mode == kvt_pkg::FIN_HIT) |-> (CW'(hit_idx_q) < count_q))
		else $error("hit index beyond valid entries");

endmodule

`default_nettype wire

// ===== design/kvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvt_ctrl: operation sequencer for the keyed value table
// Accepts words, steps the datapath through scan, read-back or clear sweep,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output kvt_pkg::cmd_t       cmd,
	input  wire kvt_pkg::stat_t stat
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_READ     = 3'd3;
	localparam logic [2:0] S_HIT      = 3'd4;
	localparam logic [2:0] S_MISS     = 3'd5;
	localparam logic [2:0] S_CLEAR    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.fin_mode = kvt_pkg::FIN_DIRECT;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.func == kvt_pkg::FN_CLEAR) begin
					cmd.scan_start = 1'b1;
					state_d        = S_CLEAR;
				end else if ((stat.func == kvt_pkg::FN_LOOKUP ||
						stat.func == kvt_pkg::FN_SET ||
						stat.func == kvt_pkg::FN_LOOK_SET) && !stat.key_zero) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.key_match) begin
					cmd.grab_hit = 1'b1;
					state_d      = S_READ;
				end else if (!stat.rd_pend && stat.scan_end) begin
					state_d = S_MISS;
				end
			end
			S_READ: begin
				cmd.read_hit = 1'b1;
				state_d      = S_HIT;
			end
			S_HIT: begin
				cmd.fin_mode = kvt_pkg::FIN_HIT;
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_MISS: begin
				cmd.fin_mode = kvt_pkg::FIN_MISS;
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.clr_run = 1'b1;
				if (stat.scan_end && out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken word");

	a_read_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> $past(stat.key_match))
		else $error("read-back entered without a key match");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DISPATCH && !out_valid_q) || $past(out_valid_q))
		else $error("operand load outside idle");

endmodule

`default_nettype wire
